// ===== sv/tcce_pkg.sv =====
// Shared types, constants and address helpers for the text console character engine.
// No dependencies; the RTL files refer to this package by scoped names, the testbench imports it.
package tcce_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int WIDE_W  = 12;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int LIN_W   = 11;
  localparam int CELL_W  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int TAB_STEP    = 4;
  localparam int TAB_W       = 3;

  localparam logic [7:0] BLANK_ATTR = 8'h0F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  typedef enum logic [2:0] {
    OP_PUT   = 3'd0,
    OP_WRITE = 3'd1,
    OP_SETCUR = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    KIND_PLAIN     = 4'd0,
    KIND_TAB       = 4'd1,
    KIND_NEWLINE   = 4'd2,
    KIND_BACKSPACE = 4'd3,
    KIND_CR        = 4'd4,
    KIND_WRITE     = 4'd5,
    KIND_SETCUR    = 4'd6,
    KIND_CLEAR     = 4'd7,
    KIND_READ      = 4'd8,
    KIND_NOP       = 4'd9
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         put_char;
    logic [7:0]         attr;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [ADDR_W-1:0]  addr;
    logic               in_range;
  } entry_t;

  function automatic logic [WIDE_W-1:0] wide_pos(logic [ROW_W-1:0] row,
                                                 logic [COL_W-1:0] col);
    wide_pos = WIDE_W'(row) * WIDE_W'(COLUMNS) + WIDE_W'(col);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    logic [WIDE_W-1:0] full;
    full = wide_pos(row, col);
    cell_addr = ADDR_W'(full);
  endfunction

  function automatic logic [LIN_W-1:0] lin_of(logic [ROW_W-1:0] row,
                                              logic [COL_W-1:0] col);
    logic [WIDE_W-1:0] full;
    full = wide_pos(row, col);
    lin_of = full[LIN_W-1:0];
  endfunction

endpackage

// ===== sv/tcce_if.sv =====
// Valid/ready channel interfaces for console commands and results.
// Depends on tcce_pkg for field widths.
interface tcce_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  op;
  logic [7:0]                  char_code;
  logic [7:0]                  attribute;
  logic [tcce_pkg::COL_W-1:0]  column;
  logic [tcce_pkg::ROW_W-1:0]  row;

  modport source (output valid, op, char_code, attribute, column, row, input ready);
  modport sink   (input valid, op, char_code, attribute, column, row, output ready);
endinterface

interface tcce_res_if;
  logic                        valid;
  logic                        ready;
  logic [tcce_pkg::CELL_W-1:0] cell_data;
  logic [tcce_pkg::COL_W-1:0]  cursor_column;
  logic [tcce_pkg::ROW_W-1:0]  cursor_row;
  logic [tcce_pkg::LIN_W-1:0]  cursor_linear;

  modport source (output valid, cell_data, cursor_column, cursor_row, cursor_linear,
                  input ready);
  modport sink   (input valid, cell_data, cursor_column, cursor_row, cursor_linear,
                  output ready);
endinterface

// ===== sv/tcce_front.sv =====
// Command front end: accepts transactions, decodes op and control characters,
// clamps and range-checks positions. Depends on tcce_pkg and tcce_if.
module tcce_front (
  tcce_cmd_if.sink          cmd_i,
  input  logic              init_busy_i,
  input  logic              full_i,
  output logic              push_o,
  output tcce_pkg::entry_t  entry_o
);

  logic col_over;
  logic row_over;

  assign cmd_i.ready = !full_i && !init_busy_i;
  assign push_o      = cmd_i.valid && cmd_i.ready;

  assign col_over = int'(cmd_i.column) >= tcce_pkg::COLUMNS;
  assign row_over = int'(cmd_i.row) >= tcce_pkg::ROWS;

  always_comb begin
    entry_o          = '0;
    entry_o.kind     = tcce_pkg::KIND_NOP;
    entry_o.put_char = cmd_i.char_code;
    entry_o.attr     = cmd_i.attribute;
    entry_o.col      = col_over ? tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1) : cmd_i.column;
    entry_o.row      = row_over ? tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1) : cmd_i.row;
    entry_o.in_range = !col_over && !row_over;
    entry_o.addr     = tcce_pkg::cell_addr(cmd_i.row, cmd_i.column);
    case (cmd_i.op)
      tcce_pkg::OP_PUT: begin
        case (cmd_i.char_code)
          tcce_pkg::CH_NL:  entry_o.kind = tcce_pkg::KIND_NEWLINE;
          tcce_pkg::CH_BS:  entry_o.kind = tcce_pkg::KIND_BACKSPACE;
          tcce_pkg::CH_CR:  entry_o.kind = tcce_pkg::KIND_CR;
          tcce_pkg::CH_TAB: begin
            entry_o.kind     = tcce_pkg::KIND_TAB;
            entry_o.put_char = tcce_pkg::CH_SPACE;
          end
          default:          entry_o.kind = tcce_pkg::KIND_PLAIN;
        endcase
      end
      tcce_pkg::OP_WRITE:  entry_o.kind = tcce_pkg::KIND_WRITE;
      tcce_pkg::OP_SETCUR: entry_o.kind = tcce_pkg::KIND_SETCUR;
      tcce_pkg::OP_CLEAR:  entry_o.kind = tcce_pkg::KIND_CLEAR;
      tcce_pkg::OP_READ:   entry_o.kind = tcce_pkg::KIND_READ;
      default:             entry_o.kind = tcce_pkg::KIND_NOP;
    endcase
  end

endmodule

// ===== sv/tcce_queue.sv =====
// Short command queue between the decode front end and the execution back end.
// Depends on tcce_pkg.
module tcce_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tcce_pkg::entry_t  entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output tcce_pkg::entry_t  entry_o
);

  localparam int PTR_W = (tcce_pkg::QUEUE_DEPTH > 1) ? $clog2(tcce_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(tcce_pkg::QUEUE_DEPTH + 1);

  tcce_pkg::entry_t  slots_q [tcce_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == CNT_W'(tcce_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign entry_o = slots_q[rptr_q];

  function automatic logic [PTR_W-1:0] inc_ptr(logic [PTR_W-1:0] p);
    inc_ptr = (p == PTR_W'(tcce_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wptr_d = push_i ? inc_ptr(wptr_q) : wptr_q;
    rptr_d = pop_i ? inc_ptr(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= entry_i;
    end
  end

endmodule

// ===== sv/tcce_back.sv =====
// Execution back end: screen store, cursor, scroll copy and fill sequencer,
// result register. Depends on tcce_pkg and tcce_if.
module tcce_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  tcce_pkg::entry_t  entry_i,
  output logic              pop_o,
  output logic              init_busy_o,
  tcce_res_if.source        res_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_FILL   = 5'b10000
  } state_e;

  localparam int AW = tcce_pkg::ADDR_W;

  logic [tcce_pkg::CELL_W-1:0] cells_mem [tcce_pkg::CELLS];
  logic [tcce_pkg::CELL_W-1:0] rdata_q;

  state_e                       state_q, state_d;
  logic [AW-1:0]                ptr_q, ptr_d;
  logic [tcce_pkg::COL_W-1:0]   cur_col_q, cur_col_d;
  logic [tcce_pkg::ROW_W-1:0]   cur_row_q, cur_row_d;
  logic [7:0]                   attr_q, attr_d;
  logic [tcce_pkg::TAB_W-1:0]   put_cnt_q, put_cnt_d;
  logic                         init_q, init_d;
  tcce_pkg::entry_t             cmd_q;

  logic                         out_valid_q;
  logic [tcce_pkg::CELL_W-1:0]  out_data_q;
  logic [tcce_pkg::COL_W-1:0]   out_col_q;
  logic [tcce_pkg::ROW_W-1:0]   out_row_q;
  logic [tcce_pkg::LIN_W-1:0]   out_lin_q;

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [tcce_pkg::CELL_W-1:0]  mem_wdata;
  logic [AW-1:0]                mem_raddr;
  logic                         finish;
  logic [tcce_pkg::CELL_W-1:0]  fin_data;
  logic [AW-1:0]                cur_addr;
  logic                         put_kind;

  assign cur_addr    = tcce_pkg::cell_addr(cur_row_q, cur_col_q);
  assign init_busy_o = init_q;
  assign pop_o       = (state_q == ST_IDLE) && !empty_i && (!out_valid_q || res_o.ready);
  assign put_kind    = (cmd_q.kind == tcce_pkg::KIND_PLAIN) ||
                       (cmd_q.kind == tcce_pkg::KIND_TAB);

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    attr_d    = attr_q;
    put_cnt_d = put_cnt_q;
    init_d    = init_q;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = {attr_q, tcce_pkg::CH_SPACE};
    mem_raddr = cmd_q.addr;
    finish    = 1'b0;
    fin_data  = '0;

    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_EXEC;
          case (entry_i.kind)
            tcce_pkg::KIND_PLAIN: put_cnt_d = tcce_pkg::TAB_W'(1);
            tcce_pkg::KIND_TAB:
              put_cnt_d = tcce_pkg::TAB_W'(tcce_pkg::TAB_STEP) -
                          tcce_pkg::TAB_W'(cur_col_q[1:0]);
            default: put_cnt_d = '0;
          endcase
        end
      end

      ST_EXEC: begin
        if (put_kind) begin
          mem_we    = 1'b1;
          mem_waddr = cur_addr;
          mem_wdata = {attr_q, cmd_q.put_char};
          put_cnt_d = put_cnt_q - 1'b1;
          if (cur_col_q == tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1)) begin
            cur_col_d = '0;
            if (cur_row_q == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1)) begin
              ptr_d   = '0;
              state_d = ST_SCROLL;
            end else begin
              cur_row_d = cur_row_q + 1'b1;
              if (put_cnt_q == tcce_pkg::TAB_W'(1)) begin
                finish  = 1'b1;
                state_d = ST_IDLE;
              end
            end
          end else begin
            cur_col_d = cur_col_q + 1'b1;
            if (put_cnt_q == tcce_pkg::TAB_W'(1)) begin
              finish  = 1'b1;
              state_d = ST_IDLE;
            end
          end
        end else begin
          finish  = 1'b1;
          state_d = ST_IDLE;
          case (cmd_q.kind)
            tcce_pkg::KIND_NEWLINE: begin
              cur_col_d = '0;
              if (cur_row_q == tcce_pkg::ROW_W'(tcce_pkg::ROWS - 1)) begin
                finish  = 1'b0;
                ptr_d   = '0;
                state_d = ST_SCROLL;
              end else begin
                cur_row_d = cur_row_q + 1'b1;
              end
            end
            tcce_pkg::KIND_BACKSPACE: begin
              if (cur_col_q != '0) begin
                cur_col_d = cur_col_q - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = cur_addr - 1'b1;
              end
            end
            tcce_pkg::KIND_CR: cur_col_d = '0;
            tcce_pkg::KIND_WRITE: begin
              mem_we    = cmd_q.in_range;
              mem_waddr = cmd_q.addr;
              mem_wdata = {cmd_q.attr, cmd_q.put_char};
            end
            tcce_pkg::KIND_SETCUR: begin
              cur_col_d = cmd_q.col;
              cur_row_d = cmd_q.row;
            end
            tcce_pkg::KIND_CLEAR: begin
              finish    = 1'b0;
              attr_d    = cmd_q.attr;
              cur_col_d = '0;
              cur_row_d = '0;
              ptr_d     = '0;
              state_d   = ST_FILL;
            end
            tcce_pkg::KIND_READ: begin
              if (cmd_q.in_range) begin
                finish  = 1'b0;
                state_d = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end

      ST_READ: begin
        fin_data = rdata_q;
        finish   = 1'b1;
        state_d  = ST_IDLE;
      end

      ST_SCROLL: begin
        // read one row ahead, write the data read in the previous cycle
        mem_raddr = ptr_q + AW'(tcce_pkg::COLUMNS);
        mem_we    = ptr_q != '0;
        mem_waddr = ptr_q - 1'b1;
        mem_wdata = rdata_q;
        if (ptr_q == AW'(tcce_pkg::CELLS - tcce_pkg::COLUMNS)) begin
          state_d = ST_FILL;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q;
        mem_wdata = {attr_q, tcce_pkg::CH_SPACE};
        if (ptr_q == AW'(tcce_pkg::CELLS - 1)) begin
          if (init_q) begin
            init_d  = 1'b0;
            state_d = ST_IDLE;
          end else if (put_cnt_q != '0) begin
            state_d = ST_EXEC;
          end else begin
            finish  = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      ptr_q       <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      attr_q      <= tcce_pkg::BLANK_ATTR;
      put_cnt_q   <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      attr_q    <= attr_d;
      put_cnt_q <= put_cnt_d;
      init_q    <= init_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= entry_i;
    end
    if (finish) begin
      out_data_q <= fin_data;
      out_col_q  <= cur_col_d;
      out_row_q  <= cur_row_d;
      out_lin_q  <= tcce_pkg::lin_of(cur_row_d, cur_col_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= cells_mem[mem_raddr];
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.cell_data     = out_data_q;
  assign res_o.cursor_column = out_col_q;
  assign res_o.cursor_row    = out_row_q;
  assign res_o.cursor_linear = out_lin_q;

endmodule

// ===== sv/text_console_character_engine_unit.sv =====
// Top level of the text console character engine: front end, command queue, back end.
// Depends on tcce_pkg, tcce_if, tcce_front, tcce_queue and tcce_back.
//
// A text-mode console with an 80x25 screen of 16-bit cells (attribute high byte,
// character low byte). Each command transaction gives exactly one result transaction
// carrying the cursor after the command and, for a read, the cell. The screen store has
// one write and one registered read port, and that port sets the timing: a read passes
// through ST_READ for the registered data, and a tab writes its spaces one at a time. A put
// or newline that scrolls walks the store once, copying rows up and then filling the bottom
// row; a clear writes every cell. After reset the store is cleared to spaces in attribute
// 0x0F, and cmd_i.ready stays low until that is done. Two commands can queue behind the
// one being executed, and a finished result waits in its own register.
module text_console_character_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcce_cmd_if.sink    cmd_i,
  tcce_res_if.source  res_o
);

  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  logic              init_busy;
  tcce_pkg::entry_t  push_entry;
  tcce_pkg::entry_t  pop_entry;

  tcce_front u_front (
    .cmd_i       (cmd_i),
    .init_busy_i (init_busy),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  tcce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (pop_entry)
  );

  tcce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (pop_entry),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .res_o       (res_o)
  );

endmodule

// ===== sv/tcce_checker.sv =====
// Port-level checks for the text console character engine, bound to the top level.
// Depends on tcce_pkg.
module tcce_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [tcce_pkg::COL_W-1:0]  cursor_column_i,
  input logic [tcce_pkg::ROW_W-1:0]  cursor_row_i,
  input logic [tcce_pkg::LIN_W-1:0]  cursor_linear_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result transaction dropped before it was taken");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> int'(cursor_column_i) < tcce_pkg::COLUMNS)
    else $error("cursor column beyond the screen");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> int'(cursor_row_i) < tcce_pkg::ROWS)
    else $error("cursor row beyond the screen");

  a_linear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> cursor_linear_i == tcce_pkg::lin_of(cursor_row_i, cursor_column_i))
    else $error("linear cursor does not match row and column");

endmodule

bind text_console_character_engine_unit tcce_checker u_tcce_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .cursor_column_i (res_o.cursor_column),
  .cursor_row_i    (res_o.cursor_row),
  .cursor_linear_i (res_o.cursor_linear)
);

// ===== tb/text_console_character_engine_unit_tb.sv =====
// Self-checking testbench for text_console_character_engine_unit: a directed run, then
// random console traffic with idle gaps and back-pressure, checked against a screen image.
// Depends on tcce_pkg, tcce_if and the RTL under sv/.
`timescale 1ns / 100ps

module text_console_character_engine_unit_tb;
  import tcce_pkg::*;

  localparam int          RANDOM_ITEMS = 1250;
  localparam int          DRAIN_EVERY  = 300;
  localparam int          TAIL_CYCLES  = 50;
  localparam longint      CYCLE_LIMIT  = 10_000_000;
  localparam logic [2:0]  OP_SPARE_LO  = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI  = 3'd7;

  typedef struct {
    logic [2:0]       op;
    logic [7:0]       ch;
    logic [7:0]       attr;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    bit               drain;
  } console_cmd_t;

  typedef struct {
    logic [CELL_W-1:0] cell_val;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [LIN_W-1:0]  lin;
  } console_report_t;

  logic clk_i;
  logic rst_ni;

  tcce_cmd_if cmd ();
  tcce_res_if res ();

  text_console_character_engine_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .res_o  (res)
  );

  // screen image and cursor state of the model
  logic [CELL_W-1:0] screen_image [CELLS];
  int                col_now;
  int                row_now;
  logic [7:0]        attr_now;

  console_cmd_t      commands_to_send [$];
  console_report_t   reports_due [$];
  console_cmd_t      next_cmd;
  console_report_t   report_now;
  bit                drain_next;
  bit                cmd_taken;
  bit                send_quiet;
  bit                recv_quiet;
  int                send_gap;
  int                recv_stall;
  int                items_total;
  int                items_accepted;
  int                err_count;
  longint            cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen_image[i] = screen_image[i + COLUMNS];
    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_image[i] = {attr_now, CH_SPACE};
  endfunction

  function automatic void settle_cursor();
    if (col_now >= COLUMNS) begin
      col_now = 0;
      row_now++;
    end
    if (row_now >= ROWS) begin
      scroll_screen();
      row_now = ROWS - 1;
    end
  endfunction

  function automatic void type_glyph(logic [7:0] ch);
    screen_image[row_now * COLUMNS + col_now] = {attr_now, ch};
    col_now++;
    settle_cursor();
  endfunction

  function automatic console_report_t run_console_op(console_cmd_t c);
    console_report_t r;
    int              n;
    r.cell_val = '0;
    case (c.op)
      OP_PUT: begin
        if (c.ch == CH_NL) begin
          col_now = 0;
          row_now++;
          settle_cursor();
        end else if (c.ch == CH_BS) begin
          if (col_now > 0) begin
            col_now--;
            screen_image[row_now * COLUMNS + col_now] = {attr_now, CH_SPACE};
          end
        end else if (c.ch == CH_TAB) begin
          n = TAB_STEP - (col_now % TAB_STEP);
          repeat (n) type_glyph(CH_SPACE);
        end else if (c.ch == CH_CR) begin
          col_now = 0;
        end else begin
          type_glyph(c.ch);
        end
      end
      OP_WRITE: begin
        if (c.col < COLUMNS && c.row < ROWS)
          screen_image[int'(c.row) * COLUMNS + int'(c.col)] = {c.attr, c.ch};
      end
      OP_SETCUR: begin
        col_now = (c.col >= COLUMNS) ? COLUMNS - 1 : int'(c.col);
        row_now = (c.row >= ROWS) ? ROWS - 1 : int'(c.row);
      end
      OP_CLEAR: begin
        foreach (screen_image[i]) screen_image[i] = {c.attr, CH_SPACE};
        col_now  = 0;
        row_now  = 0;
        attr_now = c.attr;
      end
      OP_READ: begin
        if (c.col < COLUMNS && c.row < ROWS)
          r.cell_val = screen_image[int'(c.row) * COLUMNS + int'(c.col)];
      end
      default: ;
    endcase
    r.col = COL_W'(col_now);
    r.row = ROW_W'(row_now);
    r.lin = LIN_W'(row_now * COLUMNS + col_now);
    return r;
  endfunction

  function automatic void queue_cmd(logic [2:0] op, logic [7:0] ch, logic [7:0] attr,
                                    logic [COL_W-1:0] col, logic [ROW_W-1:0] row);
    console_cmd_t c;
    c.op    = op;
    c.ch    = ch;
    c.attr  = attr;
    c.col   = col;
    c.row   = row;
    c.drain = drain_next;
    drain_next = 1'b0;
    commands_to_send.push_back(c);
  endfunction

  function automatic int pick_idle(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    err_count++;
    $display("MISMATCH %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
  endtask

  // command driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd.valid <= 1'b0;
    end else if (!cmd.valid || cmd_taken) begin
      if (send_gap > 0) begin
        cmd.valid <= 1'b0;
        send_gap--;
      end else if (commands_to_send.size() != 0 &&
                   !(commands_to_send[0].drain && reports_due.size() != 0)) begin
        next_cmd = commands_to_send.pop_front();
        cmd.valid     <= 1'b1;
        cmd.op        <= next_cmd.op;
        cmd.char_code <= next_cmd.ch;
        cmd.attribute <= next_cmd.attr;
        cmd.column    <= next_cmd.col;
        cmd.row       <= next_cmd.row;
        if ($urandom_range(0, 79) == 0) send_quiet = !send_quiet;
        send_gap = pick_idle(send_quiet);
      end else begin
        cmd.valid <= 1'b0;
      end
    end
    cmd_taken = 1'b0;
  end

  // result back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else if (recv_stall > 0) begin
      res.ready <= 1'b0;
      recv_stall--;
    end else begin
      res.ready <= 1'b1;
      if ($urandom_range(0, 79) == 0) recv_quiet = !recv_quiet;
      recv_stall = pick_idle(recv_quiet);
    end
  end

  // monitor: check results, then predict from accepted commands
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst_ni) begin
      if (res.valid && res.ready) begin
        if (reports_due.size() == 0) begin
          report_mismatch("result with nothing pending", res.cell_data, 0);
        end else begin
          report_now = reports_due.pop_front();
          if (res.cell_data !== report_now.cell_val)
            report_mismatch("cell_data", res.cell_data, report_now.cell_val);
          if (res.cursor_column !== report_now.col)
            report_mismatch("cursor_column", res.cursor_column, report_now.col);
          if (res.cursor_row !== report_now.row)
            report_mismatch("cursor_row", res.cursor_row, report_now.row);
          if (res.cursor_linear !== report_now.lin)
            report_mismatch("cursor_linear", res.cursor_linear, report_now.lin);
        end
      end
      if (cmd.valid && cmd.ready) begin
        next_cmd.op   = cmd.op;
        next_cmd.ch   = cmd.char_code;
        next_cmd.attr = cmd.attribute;
        next_cmd.col  = cmd.column;
        next_cmd.row  = cmd.row;
        reports_due.push_back(run_console_op(next_cmd));
        items_accepted++;
        cmd_taken = 1'b1;
      end
    end
  end

  initial begin
    int               roll;
    int               len;
    int               mark;
    logic [7:0]       ch;
    logic [COL_W-1:0] px;
    logic [ROW_W-1:0] py;

    rst_ni        = 1'b0;
    cmd.valid     = 1'b0;
    cmd.op        = '0;
    cmd.char_code = '0;
    cmd.attribute = '0;
    cmd.column    = '0;
    cmd.row       = '0;
    res.ready     = 1'b0;
    foreach (screen_image[i]) screen_image[i] = {BLANK_ATTR, CH_SPACE};
    col_now  = 0;
    row_now  = 0;
    attr_now = BLANK_ATTR;

    // directed
    queue_cmd(OP_READ, 8'h00, 8'h00, 0, 0);
    queue_cmd(OP_PUT, 8'hFF, 8'h00, 0, 0);
    queue_cmd(OP_PUT, 8'h00, 8'hFF, 0, 0);
    queue_cmd(OP_PUT, CH_BS, 8'h00, 0, 0);
    queue_cmd(OP_PUT, CH_TAB, 8'h00, 0, 0);
    queue_cmd(OP_PUT, CH_CR, 8'h00, 0, 0);
    queue_cmd(OP_PUT, CH_NL, 8'h00, 0, 0);
    queue_cmd(OP_READ, 8'h00, 8'h00, 0, 0);
    queue_cmd(OP_READ, 8'h00, 8'h00, 1, 0);
    queue_cmd(OP_WRITE, 8'hFF, 8'hFF, 79, 24);
    queue_cmd(OP_READ, 8'h00, 8'h00, 79, 24);
    queue_cmd(OP_WRITE, 8'h55, 8'hAA, 80, 0);
    queue_cmd(OP_WRITE, 8'h55, 8'hAA, 0, 25);
    queue_cmd(OP_WRITE, 8'h55, 8'hAA, 127, 31);
    queue_cmd(OP_READ, 8'h00, 8'h00, 127, 31);
    queue_cmd(OP_READ, 8'h00, 8'h00, 80, 0);
    queue_cmd(OP_SETCUR, 8'h00, 8'h00, 127, 31);
    queue_cmd(OP_PUT, 8'h78, 8'h00, 0, 0);
    queue_cmd(OP_READ, 8'h00, 8'h00, 79, 23);
    queue_cmd(OP_PUT, CH_NL, 8'h00, 0, 0);
    queue_cmd(OP_PUT, CH_BS, 8'h00, 0, 0);
    queue_cmd(OP_SETCUR, 8'h00, 8'h00, 76, 24);
    queue_cmd(OP_PUT, CH_TAB, 8'h00, 0, 0);
    queue_cmd(OP_SPARE_HI, 8'hFF, 8'hFF, 127, 31);
    queue_cmd(OP_CLEAR, 8'h00, 8'h00, 0, 0);
    queue_cmd(OP_SPARE_LO, 8'h00, 8'h00, 0, 0);
    drain_next = 1'b1;
    queue_cmd(OP_CLEAR, 8'hFF, 8'hA5, 127, 31);

    // random traffic
    mark = commands_to_send.size() + RANDOM_ITEMS;
    while (commands_to_send.size() < mark) begin
      if ((commands_to_send.size() % DRAIN_EVERY) < 4) drain_next = 1'b1;
      roll = $urandom_range(0, 99);
      px = ($urandom_range(0, 9) == 0) ? COL_W'($urandom_range(80, 127)) :
                                         COL_W'($urandom_range(0, 79));
      py = ($urandom_range(0, 9) == 0) ? ROW_W'($urandom_range(25, 31)) :
                                         ROW_W'($urandom_range(0, 24));
      if (roll < 40) begin
        // a line of text from a cursor position, often on the bottom row
        if ($urandom_range(0, 3) == 0) queue_cmd(OP_SETCUR, 8'h00, 8'h00, px, ROW_W'(ROWS - 1));
        else queue_cmd(OP_SETCUR, 8'($urandom), 8'($urandom), px, py);
        len = $urandom_range(3, 20);
        repeat (len) begin
          roll = $urandom_range(0, 99);
          if (roll < 70)      ch = 8'($urandom_range(8'h20, 8'h7E));
          else if (roll < 78) ch = CH_NL;
          else if (roll < 83) ch = CH_TAB;
          else if (roll < 88) ch = CH_BS;
          else if (roll < 92) ch = CH_CR;
          else                ch = 8'($urandom_range(0, 255));
          queue_cmd(OP_PUT, ch, 8'($urandom), COL_W'($urandom), ROW_W'($urandom));
        end
      end else if (roll < 60) begin
        queue_cmd(OP_WRITE, 8'($urandom), 8'($urandom), px, py);
        queue_cmd(OP_READ, 8'($urandom), 8'($urandom), px, py);
      end else if (roll < 75) begin
        queue_cmd(OP_READ, 8'($urandom), 8'($urandom), px, py);
      end else if (roll < 84) begin
        queue_cmd(OP_SETCUR, 8'($urandom), 8'($urandom), COL_W'($urandom), ROW_W'($urandom));
      end else if (roll < 90) begin
        queue_cmd(OP_PUT, 8'($urandom), 8'($urandom), COL_W'($urandom), ROW_W'($urandom));
      end else if (roll < 99) begin
        queue_cmd(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                  COL_W'($urandom), ROW_W'($urandom));
      end else begin
        queue_cmd(OP_CLEAR, 8'($urandom), 8'($urandom), COL_W'($urandom), ROW_W'($urandom));
      end
    end
    items_total = commands_to_send.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (items_accepted == items_total);
    wait (reports_due.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0 && reports_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
